// ===== sv/lwbc_pkg.sv =====
// Shared constants, types and state codes for the LRU write-back cache.
`timescale 1ns / 1ps
`default_nettype none
package lwbc_pkg;

  // Built geometry of the cache and its backing memory.
  localparam int CACHE_WAYS = 16;
  localparam int MEM_DEPTH  = 4096;

  // Derived widths.
  localparam int WAY_W  = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
  localparam int CNT_W  = $clog2(CACHE_WAYS + 1);
  localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LIM_W  = 17;

  // Field and register widths fixed by the interface.
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 32;
  localparam int CFG_WAYS_W  = 5;
  localparam int CFG_WORDS_W = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WAYS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_WORDS = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CFG_WAYS_W-1:0]  ACTIVE_WAYS_RST  = 5'd16;
  localparam logic [CFG_WORDS_W-1:0] MEMORY_WORDS_RST = 13'd4096;

  // Request kinds.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic lookup;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/lru_write_back_cache.sv =====
// Top level of the fully associative LRU write-back cache.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// A transaction is accepted at a rising clock edge at which start is high and
// busy is low; req_type_i (0 read, 1 write), address_i and write_data_i are
// sampled at that edge. Each transaction gives one result on read_data_o,
// was_hit_o and status_o, valid for exactly one cycle while done_o is high.
// The receiver cannot stall, so the result is simply taken in that cycle.
// From the accepting edge, the controller runs a lookup state for the parallel
// tag match and the memory fill read, then an update state for the way, rank
// and write-back update; the result is registered at the end of the update state.
// busy drops in the cycle that shows done_o, so a new transaction can be
// accepted in that cycle, but not before the previous one is complete.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user
// must do so only while no transaction is open, the block does not enforce it.
// After reset the backing memory is cleared one word a cycle, so busy stays high until every word is cleared.
module lru_write_back_cache (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 req_type_i,
  input  wire logic [lwbc_pkg::ADDR_W-1:0]          address_i,
  input  wire logic signed [lwbc_pkg::DATA_W-1:0]   write_data_i,
  output logic                                      done_o,
  output logic signed [lwbc_pkg::DATA_W-1:0]        read_data_o,
  output logic                                      was_hit_o,
  output logic                                      status_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lwbc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [lwbc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import lwbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller.
  lwbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath.
  lwbc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_type_i   (req_type_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .was_hit_o    (was_hit_o),
    .status_o     (status_o)
  );

endmodule
`default_nettype wire

// ===== sv/lwbc_ctrl.sv =====
// Controller state machine that sequences memory clearing and each transaction.
`timescale 1ns / 1ps
`default_nettype none
module lwbc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire lwbc_pkg::sts_t sts_i,
  output lwbc_pkg::cmd_t      cmd_o
);
  import lwbc_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Outputs: one command per state.
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      ST_CLEAR:  cmd_o.clear = 1'b1;
      ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      ST_LOOKUP: cmd_o.lookup = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/lwbc_dp.sv =====
// Datapath: configuration, way registers, tag match, LRU ranks and backing memory.
`timescale 1ns / 1ps
`default_nettype none
module lwbc_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lwbc_pkg::cmd_t                       cmd_i,
  output lwbc_pkg::sts_t                            sts_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lwbc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [lwbc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                 req_type_i,
  input  wire logic [lwbc_pkg::ADDR_W-1:0]          address_i,
  input  wire logic signed [lwbc_pkg::DATA_W-1:0]   write_data_i,
  output logic                                      done_o,
  output logic signed [lwbc_pkg::DATA_W-1:0]        read_data_o,
  output logic                                      was_hit_o,
  output logic                                      status_o
);
  import lwbc_pkg::*;

  // Configuration registers.
  logic [CFG_WAYS_W-1:0]  active_ways_q;
  logic [CFG_WORDS_W-1:0] memory_words_q;

  // Captured request.
  logic              req_type_q;
  logic [ADDR_W-1:0] req_addr_q;
  logic [DATA_W-1:0] req_wdata_q;

  // Way registers and occupancy.
  logic [MEM_AW-1:0] entry_addr_q [CACHE_WAYS];
  logic [DATA_W-1:0] entry_data_q [CACHE_WAYS];
  logic [WAY_W-1:0]  entry_rank_q [CACHE_WAYS];
  logic [CNT_W-1:0]  occ_q, occ_after;

  // Lookup results held for the update cycle.
  logic             err_q, hit_q, evict_q, alloc_q;
  logic [WAY_W-1:0] sel_q, old_rank_q;

  // Backing memory and its clearing counter.
  logic [DATA_W-1:0] mem_q [MEM_DEPTH];
  logic [DATA_W-1:0] mem_rdata_q;
  logic [MEM_AW-1:0] clr_cnt_q;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  // Result registers.
  logic              done_q, was_hit_q, status_q;
  logic [DATA_W-1:0] rd_data_q;

  // Lookup logic.
  logic                  in_range, full;
  logic [CNT_W-1:0]      eff_ways;
  logic [CACHE_WAYS-1:0] lane_occ, hit_vec, victim_vec;
  logic [WAY_W-1:0]      hit_idx, victim_idx, hit_rank, last_rank;
  logic [MEM_AW-1:0]     req_idx;
  logic [DATA_W-1:0]     sel_data;
  logic [MEM_AW-1:0]     sel_addr;

  assign req_idx  = req_addr_q[MEM_AW-1:0];
  assign sel_data = entry_data_q[sel_q];
  assign sel_addr = entry_addr_q[sel_q];

  // An address is valid below both the configured word count and the built depth.
  assign in_range = (LIM_W'(req_addr_q) < LIM_W'(memory_words_q))
                 && (LIM_W'(req_addr_q) < LIM_W'(MEM_DEPTH));

  // Clamp the configured way count to 1 .. CACHE_WAYS.
  always_comb begin
    if (active_ways_q == '0) begin
      eff_ways = CNT_W'(1);
    end else if (32'(active_ways_q) > CACHE_WAYS) begin
      eff_ways = CNT_W'(CACHE_WAYS);
    end else begin
      eff_ways = CNT_W'(active_ways_q);
    end
  end

  assign full      = (occ_q >= eff_ways);
  assign last_rank = WAY_W'(occ_q - CNT_W'(1));

  // Parallel tag match and victim search over the occupied ways.
  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    hit_rank   = '0;
    for (int i = 0; i < CACHE_WAYS; i++) begin
      lane_occ[i]   = (CNT_W'(i) < occ_q);
      hit_vec[i]    = lane_occ[i] && (entry_addr_q[i] == req_idx);
      victim_vec[i] = lane_occ[i] && (entry_rank_q[i] == last_rank);
      hit_rank      = hit_rank | (hit_vec[i] ? entry_rank_q[i] : '0);
    end
    for (int i = CACHE_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = WAY_W'(i);
      if (victim_vec[i]) victim_idx = WAY_W'(i);
    end
  end

  // Occupancy after this transaction's allocation.
  assign occ_after = alloc_q ? occ_q + CNT_W'(1) : occ_q;

  // Clearing pass status.
  assign sts_o.clear_last = (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1));

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_ways_q  <= ACTIVE_WAYS_RST;
      memory_words_q <= MEMORY_WORDS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_WAYS:  active_ways_q  <= cfg_wdata_i[CFG_WAYS_W-1:0];
        CFG_MEMORY_WORDS: memory_words_q <= cfg_wdata_i[CFG_WORDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state: occupancy, clear counter and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      done_q <= cmd_i.update;
      if (cmd_i.clear) clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
      if (cmd_i.update && !err_q) occ_q <= occ_after;
    end
  end

  // Request capture and lookup decisions.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q  <= req_type_i;
      req_addr_q  <= address_i;
      req_wdata_q <= write_data_i;
    end
    if (cmd_i.lookup) begin
      err_q   <= !in_range;
      hit_q   <= |hit_vec;
      evict_q <= !(|hit_vec) && full;
      alloc_q <= !(|hit_vec) && !full;
      if (|hit_vec) begin
        sel_q      <= hit_idx;
        old_rank_q <= hit_rank;
      end else if (full) begin
        sel_q      <= victim_idx;
        old_rank_q <= last_rank;
      end else begin
        sel_q      <= WAY_W'(occ_q);
        old_rank_q <= WAY_W'(occ_q);
      end
    end
  end

  // Way update: move the selected way to the front, store the address on a miss and the data on a write or a fill.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && !err_q) begin
      for (int i = 0; i < CACHE_WAYS; i++) begin
        if (WAY_W'(i) == sel_q) begin
          entry_rank_q[i] <= '0;
        end else if ((CNT_W'(i) < occ_after) && (entry_rank_q[i] < old_rank_q)) begin
          entry_rank_q[i] <= entry_rank_q[i] + WAY_W'(1);
        end
      end
      if (!hit_q) entry_addr_q[sel_q] <= req_idx;
      if (req_type_q == REQ_WRITE) begin
        entry_data_q[sel_q] <= req_wdata_q;
      end else if (!hit_q) begin
        entry_data_q[sel_q] <= mem_rdata_q;
      end
    end
  end

  // Memory write port: clearing pass or write-back of the evicted way.
  always_comb begin
    mem_we    = cmd_i.clear || (cmd_i.update && !err_q && evict_q);
    mem_waddr = cmd_i.clear ? clr_cnt_q : sel_addr;
    mem_wdata = cmd_i.clear ? '0 : sel_data;
  end

  // Backing memory with registered read for the fill.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (cmd_i.lookup && in_range) mem_rdata_q <= mem_q[req_idx];
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      status_q  <= err_q;
      was_hit_q <= !err_q && hit_q;
      if (err_q || (req_type_q == REQ_WRITE)) begin
        rd_data_q <= '0;
      end else if (hit_q) begin
        rd_data_q <= sel_data;
      end else begin
        rd_data_q <= mem_rdata_q;
      end
    end
  end

  assign done_o      = done_q;
  assign read_data_o = rd_data_q;
  assign was_hit_o   = was_hit_q;
  assign status_o    = status_q;

`ifndef SYNTH
  // Occupancy never exceeds the built way count.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(CACHE_WAYS))
    else $error("occupancy above way count");

  // An address is cached in at most one way.
  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup |-> $onehot0(hit_vec))
    else $error("address cached in more than one way");

  // A miss on a full cache always finds exactly one least recent way.
  a_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.lookup && in_range && !(|hit_vec) && full) |-> $onehot(victim_vec))
    else $error("no unique victim way");

  // An out-of-range transaction returns zero data and no hit.
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q) |-> (rd_data_q == '0) && !was_hit_q)
    else $error("error result carries data");

  // Occupancy changes only in the update cycle of an allocating transaction.
  a_occ_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(occ_q) |-> $past(cmd_i.update && alloc_q && !err_q))
    else $error("unexpected occupancy change");
`endif

endmodule
`default_nettype wire

// ===== tb/lru_write_back_cache_test.sv =====
// Self-checking testbench for the fully associative LRU write-back cache.
`timescale 1ns / 1ps
module lru_write_back_cache_test;
  import lwbc_pkg::*;

  // Cycles without any accepted request or result before the run is abandoned.
  localparam int IDLE_LIMIT = 20000;
  // Cycles allowed after the last result for stray results to show up.
  localparam int DRAIN_CYCLES = 6;

  // One expected or observed cache answer.
  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic                     was_hit;
    logic                     status;
  } cache_answer_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     req_type_i = REQ_READ;
  logic [ADDR_W-1:0]        address_i = '0;
  logic signed [DATA_W-1:0] write_data_i = '0;
  logic                     done_o;
  logic signed [DATA_W-1:0] read_data_o;
  logic                     was_hit_o;
  logic                     status_o;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = CFG_ACTIVE_WAYS;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i = '0;

  // Shadow copy of the cache contents, the backing memory and the registers.
  logic [DATA_W-1:0]      shadow_memory [MEM_DEPTH];
  logic [MEM_AW-1:0]      way_address [CACHE_WAYS];
  logic [DATA_W-1:0]      way_data [CACHE_WAYS];
  logic [WAY_W-1:0]       way_rank [CACHE_WAYS];
  logic [CNT_W-1:0]       ways_filled = '0;
  logic [CFG_WAYS_W-1:0]  active_ways_reg = ACTIVE_WAYS_RST;
  logic [CFG_WORDS_W-1:0] memory_words_reg = MEMORY_WORDS_RST;

  cache_answer_t pending_answers [$];
  int            error_count = 0;
  int            idle_cycles = 0;
  int            send_idle_pct = 24;
  bit            start_held = 1'b0;

  lru_write_back_cache i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .was_hit_o    (was_hit_o),
    .status_o     (status_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Free-running clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    foreach (shadow_memory[i]) shadow_memory[i] = '0;
  end

  // Move a way to the front; every filled way more recent than it ages by one.
  function automatic void make_most_recent(int way, logic [WAY_W-1:0] old_rank);
    for (int i = 0; i < int'(ways_filled) && i < CACHE_WAYS; i++) begin
      if (i != way && way_rank[i] < old_rank) way_rank[i] = way_rank[i] + 1'b1;
    end
    way_rank[way] = '0;
  endfunction

  // Compute the answer to one request and update the shadow state.
  task automatic predict_access(input logic req, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] wdata,
                                output cache_answer_t answer);
    int               limit;
    int               ways;
    int               way;
    bit               found;
    logic [WAY_W-1:0] oldest;
    answer = '0;
    limit = (int'(memory_words_reg) < MEM_DEPTH) ? int'(memory_words_reg) : MEM_DEPTH;
    if (int'(addr) >= limit) begin
      answer.status = 1'b1;
      return;
    end
    ways = int'(active_ways_reg);
    if (ways == 0) ways = 1;
    if (ways > CACHE_WAYS) ways = CACHE_WAYS;

    // Look for the address among the filled ways.
    found = 1'b0;
    way = 0;
    for (int i = 0; i < int'(ways_filled) && i < CACHE_WAYS; i++) begin
      if (!found && way_address[i] == addr[MEM_AW-1:0]) begin
        way = i;
        found = 1'b1;
      end
    end

    if (found) begin
      make_most_recent(way, way_rank[way]);
      if (req == REQ_WRITE) way_data[way] = wdata;
      else answer.read_data = way_data[way];
      answer.was_hit = 1'b1;
      return;
    end

    // Miss: take a free way or evict the least recent one with write-back.
    if (int'(ways_filled) < ways) begin
      way = int'(ways_filled);
      ways_filled = ways_filled + 1'b1;
      way_rank[way] = WAY_W'(ways_filled - 1'b1);
    end else begin
      oldest = '0;
      way = 0;
      for (int i = 0; i < int'(ways_filled) && i < CACHE_WAYS; i++) begin
        if (way_rank[i] >= oldest) begin
          oldest = way_rank[i];
          way = i;
        end
      end
      shadow_memory[way_address[way]] = way_data[way];
    end
    make_most_recent(way, way_rank[way]);
    way_address[way] = addr[MEM_AW-1:0];
    if (req == REQ_WRITE) begin
      way_data[way] = wdata;
    end else begin
      way_data[way] = shadow_memory[addr[MEM_AW-1:0]];
      answer.read_data = way_data[way];
    end
  endtask

  // Present one request, hold it until accepted, then maybe leave a gap.
  task automatic send_request(input logic req, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata);
    cache_answer_t answer;
    start <= 1'b1;
    start_held = 1'b1;
    req_type_i <= req;
    address_i <= addr;
    write_data_i <= wdata;
    do @(posedge clk_i); while (busy);
    predict_access(req, addr, wdata, answer);
    pending_answers.push_back(answer);
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      start_held = 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Stop issuing requests and wait until every outstanding answer has arrived.
  task automatic finish_outstanding();
    if (start_held) begin
      start <= 1'b0;
      start_held = 1'b0;
    end
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // Write one configuration register once the cache is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    finish_outstanding();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (idx == CFG_ACTIVE_WAYS) active_ways_reg = value[CFG_WAYS_W-1:0];
    else memory_words_reg = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Print a mismatch and count it.
  task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] expected,
                                 input logic signed [DATA_W-1:0] actual);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, expected, actual);
    error_count++;
  endtask

  // Compare each result with the oldest expected answer.
  always @(posedge clk_i) begin : check_answers
    cache_answer_t expected;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result, pending count", 0, 1);
      end else begin
        expected = pending_answers.pop_front();
        if (read_data_o !== expected.read_data)
          report_mismatch("read_data", expected.read_data, read_data_o);
        if (was_hit_o !== expected.was_hit)
          report_mismatch("was_hit", DATA_W'(expected.was_hit), DATA_W'(was_hit_o));
        if (status_o !== expected.status)
          report_mismatch("status", DATA_W'(expected.status), DATA_W'(status_o));
      end
    end
  end

  // Give up when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset register values: a miss, a write at the top address and its hit.
  task automatic test_reset_defaults();
    send_request(REQ_READ, 16'd0, 32'd0);
    send_request(REQ_WRITE, 16'd4095, 32'h7fff_ffff);
    send_request(REQ_READ, 16'd4095, 32'd0);
  endtask

  // Extreme data values and addresses far outside the memory.
  task automatic test_field_extremes();
    send_request(REQ_WRITE, 16'd0, 32'h8000_0000);
    send_request(REQ_WRITE, 16'hffff, 32'hffff_ffff);
    send_request(REQ_READ, 16'd4096, 32'hffff_ffff);
    send_request(REQ_READ, 16'd0, 32'd0);
    send_request(REQ_WRITE, 16'd1, 32'd0);
  endtask

  // Range check, including cached addresses that fall outside a smaller range.
  task automatic test_address_range();
    write_register(CFG_MEMORY_WORDS, 13'd3);
    send_request(REQ_READ, 16'd1, 32'd0);
    send_request(REQ_READ, 16'd4095, 32'd0);
    send_request(REQ_READ, 16'd3, 32'd0);
    write_register(CFG_MEMORY_WORDS, 13'd0);
    send_request(REQ_READ, 16'd0, 32'd0);
    write_register(CFG_MEMORY_WORDS, 13'd8191);
    send_request(REQ_READ, 16'd4095, 32'd0);
    send_request(REQ_READ, 16'd4096, 32'd0);
    write_register(CFG_MEMORY_WORDS, 13'd1);
    send_request(REQ_READ, 16'd0, 32'd0);
  endtask

  // A way count of zero behaves as one; counts above the built size saturate.
  task automatic test_way_limits();
    write_register(CFG_MEMORY_WORDS, 13'd4096);
    write_register(CFG_ACTIVE_WAYS, 13'd0);
    send_request(REQ_READ, 16'd2, 32'd0);
    send_request(REQ_READ, 16'd2, 32'd0);
    write_register(CFG_ACTIVE_WAYS, 13'd31);
    send_request(REQ_READ, 16'd5, 32'd0);
  endtask

  // Shrunk way count: evictions write back, and a later read fills that data.
  task automatic test_writeback_fill();
    write_register(CFG_ACTIVE_WAYS, 13'd2);
    send_request(REQ_WRITE, 16'd7, 32'h1234_5678);
    send_request(REQ_READ, 16'd8, 32'd0);
    send_request(REQ_READ, 16'd9, 32'd0);
    send_request(REQ_READ, 16'd7, 32'd0);
  endtask

  // Random traffic in chunks, each under a fresh random configuration.
  task automatic test_random_traffic(input int item_count, input int idle_pct);
    int               working_set;
    int               pick;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    send_idle_pct = idle_pct;
    for (int n = 0; n < item_count; n++) begin
      if (n % 50 == 0) begin
        pick = $urandom_range(99);
        write_register(CFG_ACTIVE_WAYS,
                       CFG_DATA_W'((pick < 75) ? $urandom_range(1, 6)
                                               : $urandom_range(0, 31)));
        pick = $urandom_range(99);
        if (pick < 60) write_register(CFG_MEMORY_WORDS, CFG_DATA_W'($urandom_range(8, 64)));
        else if (pick < 80) write_register(CFG_MEMORY_WORDS, 13'd4096);
        else write_register(CFG_MEMORY_WORDS, CFG_DATA_W'($urandom_range(0, 8191)));
        working_set = $urandom_range(4, 24);
      end
      // Mostly a small working set so that hits and evictions are frequent.
      pick = $urandom_range(99);
      if (pick < 70) addr = ADDR_W'($urandom_range(0, working_set - 1));
      else if (pick < 85) addr = ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
      else if (pick < 93) addr = ADDR_W'($urandom());
      else addr = ADDR_W'(int'(memory_words_reg) - 1 + int'($urandom_range(0, 1)));
      pick = $urandom_range(99);
      if (pick < 70) wdata = $urandom();
      else if (pick < 80) wdata = 32'h8000_0000;
      else if (pick < 90) wdata = 32'h7fff_ffff;
      else wdata = ($urandom_range(1) == 1) ? 32'hffff_ffff : 32'd0;
      send_request($urandom_range(1) == 1 ? REQ_WRITE : REQ_READ, addr, wdata);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The memory is cleared after reset; wait until the cache takes requests.
    do @(posedge clk_i); while (busy);

    test_reset_defaults();
    test_field_extremes();
    test_address_range();
    test_way_limits();
    test_writeback_fill();
    test_random_traffic(250, 24);
    test_random_traffic(250, 61);
    test_random_traffic(250, 0);

    finish_outstanding();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lwbc_pkg.sv
sv/lwbc_ctrl.sv
sv/lwbc_dp.sv
sv/lru_write_back_cache.sv
tb/lru_write_back_cache_test.sv
